@@ sv/fwrm_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the FIFO with running maximum.
// Used by fwrm_ctrl, fwrm_dp and fifo_with_running_maximum.
`default_nettype none

package fwrm_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [1:0] ST_DONE       = 2'd0;
  localparam logic [1:0] ST_PUSH_FULL  = 2'd1;
  localparam logic [1:0] ST_POP_EMPTY  = 2'd2;

  // Request kinds carried on tuser
  localparam logic REQ_PUSH = 1'b0;
  localparam logic REQ_POP  = 1'b1;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic load_req;    // capture the request word and its status
    logic req_pop;     // kind of the request being captured
    logic prune_rd;    // read the deque tail entry
    logic prune_drop;  // drop the deque tail entry
    logic write;       // append the word to queue and deque
    logic pop_apply;   // retire the front word
    logic out_load;    // load the result register
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic full;
    logic empty;
    logic max_any;     // deque holds at least one entry
    logic prune_less;  // read tail entry is smaller than the new word
    logic out_free;    // result register can take a beat
  } sts_t;

endpackage

`default_nettype wire

@@ sv/fwrm_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine for the FIFO with running maximum.
// Depends on fwrm_pkg for the command and status structs.
`default_nettype none

module fwrm_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_axis_tvalid_i,
  input  wire logic          s_axis_tuser_i,
  output logic               s_axis_tready_o,
  input  wire fwrm_pkg::sts_t sts_i,
  output fwrm_pkg::cmd_t     cmd_o
);
  import fwrm_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_PRUNE  = 8'b0000_0010,
    S_PCMP   = 8'b0000_0100,
    S_WRITE  = 8'b0000_1000,
    S_POPRD  = 8'b0001_0000,
    S_POPCMP = 8'b0010_0000,
    S_FETCH  = 8'b0100_0000,
    S_RESULT = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.req_pop = s_axis_tuser_i;
    s_axis_tready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        s_axis_tready_o = 1'b1;
        if (s_axis_tvalid_i) begin
          cmd_o.load_req = 1'b1;
          if (s_axis_tuser_i == REQ_POP) begin
            state_d = sts_i.empty ? S_FETCH : S_POPRD;
          end else begin
            state_d = sts_i.full ? S_FETCH : S_PRUNE;
          end
        end
      end
      S_PRUNE: begin
        if (sts_i.max_any) begin
          cmd_o.prune_rd = 1'b1;
          state_d = S_PCMP;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_PCMP: begin
        if (sts_i.prune_less) begin
          cmd_o.prune_drop = 1'b1;
          state_d = S_PRUNE;
        end else begin
          state_d = S_WRITE;
        end
      end
      S_WRITE: begin
        cmd_o.write = 1'b1;
        state_d = S_FETCH;
      end
      S_POPRD: begin
        state_d = S_POPCMP;
      end
      S_POPCMP: begin
        cmd_o.pop_apply = 1'b1;
        state_d = S_FETCH;
      end
      S_FETCH: begin
        state_d = S_RESULT;
      end
      S_RESULT: begin
        // hold until the result register frees up
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/fwrm_dp.sv @@
`timescale 1ns / 1ps
// Datapath for the FIFO with running maximum: word ring, monotonic deque
// ring, pointers, compare and result register. Depends on fwrm_pkg.
`default_nettype none

module fwrm_dp #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned CNT_W = $clog2(DEPTH + 1),
  parameter int unsigned OUT_W = ((2 + 2 * 32 + CNT_W + 1 + 7) / 8) * 8
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic signed [31:0]  value_i,
  input  wire fwrm_pkg::cmd_t      cmd_i,
  output fwrm_pkg::sts_t           sts_o,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [OUT_W-1:0]         m_axis_tdata_o
);
  import fwrm_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned RES_W = 2 + 2 * WORD_W + CNT_W + 1;
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  logic signed [WORD_W-1:0] item_mem [DEPTH];
  logic signed [WORD_W-1:0] max_mem  [DEPTH];

  logic [PTR_W-1:0] item_head_q, item_tail_q, max_head_q, max_tail_q;
  logic [CNT_W-1:0] item_total_q, max_total_q;
  logic signed [WORD_W-1:0] value_q, item_rd_q, max_rd_q;
  logic [1:0] status_q;
  logic [PTR_W-1:0] max_tail_prev, max_rd_addr;
  logic out_valid_q;
  logic [RES_W-1:0] res_d;
  logic [OUT_W-1:0] out_q;
  logic empty;

  function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
    ptr_next = (p == PTR_LAST) ? '0 : p + PTR_W'(1);
  endfunction

  function automatic logic [PTR_W-1:0] ptr_prev(input logic [PTR_W-1:0] p);
    ptr_prev = (p == '0) ? PTR_LAST : p - PTR_W'(1);
  endfunction

  assign empty         = (item_total_q == '0);
  assign max_tail_prev = ptr_prev(max_tail_q);
  assign max_rd_addr   = cmd_i.prune_rd ? max_tail_prev : max_head_q;

  assign sts_o.full       = (item_total_q == CNT_FULL);
  assign sts_o.empty      = empty;
  assign sts_o.max_any    = (max_total_q != '0);
  assign sts_o.prune_less = (max_rd_q < value_q);
  assign sts_o.out_free   = !out_valid_q || m_axis_tready_i;

  // Memories: one write and one registered read each
  always_ff @(posedge clk_i) begin
    if (cmd_i.write) begin
      item_mem[item_tail_q] <= value_q;
      max_mem[max_tail_q]   <= value_q;
    end
    item_rd_q <= item_mem[item_head_q];
    max_rd_q  <= max_mem[max_rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      value_q <= value_i;
      if (cmd_i.req_pop == REQ_POP) begin
        status_q <= empty ? ST_POP_EMPTY : ST_DONE;
      end else begin
        status_q <= sts_o.full ? ST_PUSH_FULL : ST_DONE;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_head_q  <= '0;
      item_tail_q  <= '0;
      item_total_q <= '0;
      max_head_q   <= '0;
      max_tail_q   <= '0;
      max_total_q  <= '0;
    end else begin
      if (cmd_i.prune_drop) begin
        max_tail_q  <= max_tail_prev;
        max_total_q <= max_total_q - CNT_W'(1);
      end
      if (cmd_i.write) begin
        max_tail_q   <= ptr_next(max_tail_q);
        max_total_q  <= max_total_q + CNT_W'(1);
        item_tail_q  <= ptr_next(item_tail_q);
        item_total_q <= item_total_q + CNT_W'(1);
      end
      if (cmd_i.pop_apply) begin
        // retire the deque head when it is the departing word
        if (sts_o.max_any && (max_rd_q == item_rd_q)) begin
          max_head_q  <= ptr_next(max_head_q);
          max_total_q <= max_total_q - CNT_W'(1);
        end
        item_head_q  <= ptr_next(item_head_q);
        item_total_q <= item_total_q - CNT_W'(1);
      end
    end
  end

  always_comb begin
    res_d = {empty,
             item_total_q,
             (empty || !sts_o.max_any) ? {WORD_W{1'b0}} : max_rd_q,
             empty ? {WORD_W{1'b0}} : item_rd_q,
             status_q};
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_q <= OUT_W'(res_d);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_q;

endmodule

`default_nettype wire

@@ sv/fifo_with_running_maximum.sv @@
`timescale 1ns / 1ps
// FIFO of signed words that reports the largest word it holds.
// Instantiates fwrm_ctrl and fwrm_dp; depends on fwrm_pkg.
//
// Usage: each input beat is one request. tuser selects push (0) or pop (1),
// tdata carries the word to push. Each request gives exactly one result beat
// with status, front word, maximum, count and empty flag after the request.
// Front and maximum read as zero when the queue is empty.
// One request is in flight at a time; s_axis_tready_o is high only while
// the controller is idle. From acceptance to the result load, a rejected
// request goes through fetch and result; a pop reads the front, retires
// it, then fetches; a push reads and drops deque tail entries while they
// are smaller than the new word, then writes, fetches and loads the result.
// The next request is taken in the cycle after the load at the earliest.
// The deque scan reads the tail entries one at a time through the single
// read port of the deque memory, so a push that drops many entries costs
// most; each word is dropped from the deque at most once.
// The result sits in an output register: when the receiver stalls, it holds
// there and the next request waits in the result state until it drains.
// Reset empties both rings; stored words are not cleared.
`default_nettype none

module fifo_with_running_maximum #(
  parameter int unsigned DEPTH = 16
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid_i,
  output logic              s_axis_tready_o,
  input  wire logic [31:0]  s_axis_tdata_i,   // [31:0] value
  input  wire logic         s_axis_tuser_i,   // [0] req_type
  output logic              m_axis_tvalid_o,
  input  wire logic         m_axis_tready_i,
  // [1:0] status, [33:2] front_value, [65:34] max_value,
  // [65+CNT_W:66] item_count, next bit is_empty, zero padded to bytes
  output logic [((2 + 64 + $clog2(DEPTH + 1) + 1 + 7) / 8) * 8 - 1:0] m_axis_tdata_o
);
  import fwrm_pkg::*;

  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam int unsigned OUT_W = ((2 + 2 * WORD_W + CNT_W + 1 + 7) / 8) * 8;

  cmd_t cmd;
  sts_t sts;

  fwrm_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .s_axis_tready_o (s_axis_tready_o),
    .sts_i           (sts),
    .cmd_o           (cmd)
  );

  fwrm_dp #(
    .DEPTH (DEPTH),
    .CNT_W (CNT_W),
    .OUT_W (OUT_W)
  ) u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .value_i         (s_axis_tdata_i),
    .cmd_i           (cmd),
    .sts_o           (sts),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  logic [1:0]       res_status;
  logic [CNT_W-1:0] res_count;
  logic             res_empty;

  assign res_status = m_axis_tdata_o[1:0];
  assign res_count  = m_axis_tdata_o[2 + 2 * WORD_W +: CNT_W];
  assign res_empty  = m_axis_tdata_o[2 + 2 * WORD_W + CNT_W];

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while another is in flight");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_count <= CNT_W'(DEPTH)))
    else $error("item count above depth");

  a_empty_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_empty == (res_count == '0)))
    else $error("empty flag disagrees with count");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (res_status == ST_DONE || res_status == ST_PUSH_FULL ||
                         res_status == ST_POP_EMPTY))
    else $error("undefined status code");

  a_reject_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && res_status == ST_POP_EMPTY) |-> res_empty)
    else $error("pop rejected on a non-empty queue");

endmodule

`default_nettype wire
